// File: sv/qvr_pkg.sv
// Shared constants and types for the quaternion vector rotation pipeline.
`default_nettype none

package qvr_pkg;

    // Default component width (signed fixed point, width-1 fraction bits).
    localparam int DATA_WIDTH_DEF = 16;

    // Configuration register index width and register map.
    localparam int REG_IDX_W = 2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_ROT_W = 2'd0,
        REG_ROT_X = 2'd1,
        REG_ROT_Y = 2'd2,
        REG_ROT_Z = 2'd3
    } t_reg_idx;

    // Hamilton product basis table, components ordered w, x, y, z.
    // e_i * e_j = +/- e_(i xor j); bit j of row i is set where the term is negated.
    localparam logic [3:0] HAM_NEG [4] = '{
        4'b0000,   // w * (w, x, y, z)
        4'b1010,   // x*x = -1, x*z = -y
        4'b0110,   // y*x = -z, y*y = -1
        4'b1100    // z*y = -x, z*z = -1
    };

endpackage

`default_nettype wire

// File: sv/qvr_mul_stage.sv
// Pipeline stage that registers the full 4x4 outer product of two quaternions.
`default_nettype none

module qvr_mul_stage #(
    parameter int W = qvr_pkg::DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic signed [W-1:0]   i_a [4],
    input  logic signed [W-1:0]   i_b [4],
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic signed [2*W-1:0] o_prod [4][4]
);

    logic                  r_valid;
    logic                  n_valid;
    logic signed [2*W-1:0] r_prod [4][4];

    // Advance whenever the stage is empty or its content moves on.
    assign o_ready = !r_valid || i_ready;
    assign n_valid = o_ready ? i_valid : r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    r_prod[i][j] <= i_a[i] * i_b[j];
                end
            end
        end
    end

    assign o_valid = r_valid;
    assign o_prod  = r_prod;

endmodule

`default_nettype wire

// File: sv/qvr_sum_stage.sv
// Pipeline stage that sums Hamilton terms, rounds to nearest and saturates.
`default_nettype none

module qvr_sum_stage #(
    parameter int W      = qvr_pkg::DATA_WIDTH_DEF,
    parameter bit CONJ_B = 1'b0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic signed [2*W-1:0] i_prod [4][4],
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic signed [W-1:0]   o_res [4]
);

    localparam int SW = 2 * W + 2;
    localparam int F  = W - 1;
    localparam logic signed [SW-1:0] HALF = SW'(1) << (F - 1);
    localparam logic signed [SW-1:0] MAXV = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [SW-1:0] MINV = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};

    logic                r_valid;
    logic                n_valid;
    logic signed [W-1:0] r_res [4];
    logic signed [W-1:0] n_res [4];
    logic signed [SW-1:0] acc [4];
    logic signed [SW-1:0] shifted [4];

    // Exact sum of the four terms that land on each output component,
    // then floor((sum + half) / 2^F) and clamp.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            acc[k] = '0;
            for (int i = 0; i < 4; i++) begin
                if (qvr_pkg::HAM_NEG[i][i ^ k] ^ (CONJ_B && ((i ^ k) != 0))) begin
                    acc[k] = acc[k] - SW'(i_prod[i][i ^ k]);
                end else begin
                    acc[k] = acc[k] + SW'(i_prod[i][i ^ k]);
                end
            end
            shifted[k] = (acc[k] + HALF) >>> F;
            if (shifted[k] > MAXV) begin
                n_res[k] = MAXV[W-1:0];
            end else if (shifted[k] < MINV) begin
                n_res[k] = MINV[W-1:0];
            end else begin
                n_res[k] = shifted[k][W-1:0];
            end
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign n_valid = o_ready ? i_valid : r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

// File: sv/quaternion_vector_rotate.sv
// Stages: two multiply and two sum stages, each registered, from input transfer to result valid.
// Throughput: one point per cycle when not stalled; four stage registers hold a point each.
// Stall: ready propagates back from the output register, so a full pipe holds in place.
// Reset: synchronous, active low; clears all stage valid bits and loads q = (max, 0, 0, 0).
// Results appear in input order; the rotation registers are read directly by both
// multiply stages, so write them only while the pipe is empty.
`default_nettype none

module quaternion_vector_rotate #(
    parameter int DATA_WIDTH = qvr_pkg::DATA_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [qvr_pkg::REG_IDX_W-1:0]      i_cfg_index,
    input  logic [DATA_WIDTH-1:0]              i_cfg_data,
    // point input channel
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [DATA_WIDTH-1:0]       i_point_x,
    input  logic signed [DATA_WIDTH-1:0]       i_point_y,
    input  logic signed [DATA_WIDTH-1:0]       i_point_z,
    // rotated point output channel
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [DATA_WIDTH-1:0]       o_out_w,
    output logic signed [DATA_WIDTH-1:0]       o_out_x,
    output logic signed [DATA_WIDTH-1:0]       o_out_y,
    output logic signed [DATA_WIDTH-1:0]       o_out_z
);

    localparam int W = DATA_WIDTH;

    // Rotation quaternion registers, reset to the identity rotation.
    logic signed [W-1:0] r_rot [4];

    // Point as a pure quaternion (0, x, y, z) and q in w, x, y, z order.
    logic signed [W-1:0] p_vec [4];

    // Stage handshakes: valid moves forward, ready moves back.
    logic                  s1_valid, s1_ready;
    logic                  s2_valid, s2_ready;
    logic                  s3_valid, s3_ready;
    logic signed [2*W-1:0] s1_prod [4][4];
    logic signed [W-1:0]   s2_t    [4];
    logic signed [2*W-1:0] s3_prod [4][4];
    logic signed [W-1:0]   s4_r    [4];

    // Write the rotation registers; every index of the port maps to one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot[0] <= {1'b0, {(W-1){1'b1}}};
            r_rot[1] <= '0;
            r_rot[2] <= '0;
            r_rot[3] <= '0;
        end else if (i_cfg_we) begin
            unique case (qvr_pkg::t_reg_idx'(i_cfg_index))
                qvr_pkg::REG_ROT_W: r_rot[0] <= i_cfg_data;
                qvr_pkg::REG_ROT_X: r_rot[1] <= i_cfg_data;
                qvr_pkg::REG_ROT_Y: r_rot[2] <= i_cfg_data;
                qvr_pkg::REG_ROT_Z: r_rot[3] <= i_cfg_data;
            endcase
        end
    end

    assign p_vec[0] = '0;
    assign p_vec[1] = i_point_x;
    assign p_vec[2] = i_point_y;
    assign p_vec[3] = i_point_z;

    // Stage 1: outer product of p and q.
    qvr_mul_stage #(.W(W)) u_mul_pq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_a     (p_vec),
        .i_b     (r_rot),
        .o_valid (s1_valid),
        .i_ready (s1_ready),
        .o_prod  (s1_prod)
    );

    // Stage 2: t = p * conj(q); conjugation flips the sign of terms on q's vector part,
    // so q itself is never negated (the most negative value would overflow).
    qvr_sum_stage #(.W(W), .CONJ_B(1'b1)) u_sum_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_prod  (s1_prod),
        .o_valid (s2_valid),
        .i_ready (s2_ready),
        .o_res   (s2_t)
    );

    // Stage 3: outer product of q and t.
    qvr_mul_stage #(.W(W)) u_mul_qt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .o_ready (s2_ready),
        .i_a     (r_rot),
        .i_b     (s2_t),
        .o_valid (s3_valid),
        .i_ready (s3_ready),
        .o_prod  (s3_prod)
    );

    // Stage 4: r = q * t, rounded and saturated into the output register.
    qvr_sum_stage #(.W(W), .CONJ_B(1'b0)) u_sum_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s3_valid),
        .o_ready (s3_ready),
        .i_prod  (s3_prod),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (s4_r)
    );

    assign o_out_w = s4_r[0];
    assign o_out_x = s4_r[1];
    assign o_out_y = s4_r[2];
    assign o_out_z = s4_r[3];

endmodule

`default_nettype wire

// File: sv/qvr_checker.sv
// Port-level checker for the quaternion rotation pipeline, bound to the top level.
`default_nettype none

module qvr_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_valid,
    input wire logic o_ready,
    input wire logic o_valid,
    input wire logic i_ready
);

    // Reset empties every stage: no result and room for a new point.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_ready)
        else $error("input not ready right after reset");

    // With the sink always taking, a transfer comes out at the output.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) ##1 i_ready ##1 i_ready ##1 i_ready |=> o_valid)
        else $error("point lost in the pipeline");

    // Hold a result until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid)
        else $error("result dropped before transfer");

endmodule

bind quaternion_vector_rotate qvr_checker u_qvr_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready)
);

`default_nettype wire

// File: tb/sv/tb.sv
// Testbench for quaternion_vector_rotate: self-checking stream test against an in-bench predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     DW   = qvr_pkg::DATA_WIDTH_DEF;
    localparam longint MAXV = (longint'(1) <<< (DW - 1)) - 1;
    localparam longint MINV = -MAXV - 1;
    // Pipe depth is four stages; give the drain a little slack on top.
    localparam int     SETTLE_CYCLES = 8;

    typedef struct {
        logic signed [DW-1:0] x, y, z;
    } t_point;

    typedef struct {
        logic signed [DW-1:0] w, x, y, z;
    } t_quat;

    // Clock, reset and DUT inputs, all known from time zero.
    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_cfg_we    = 1'b0;
    logic [qvr_pkg::REG_IDX_W-1:0] i_cfg_index = '0;
    logic [DW-1:0]                 i_cfg_data  = '0;
    logic                          i_valid     = 1'b0;
    logic signed [DW-1:0]          i_point_x   = '0;
    logic signed [DW-1:0]          i_point_y   = '0;
    logic signed [DW-1:0]          i_point_z   = '0;
    logic                          i_ready     = 1'b0;
    logic                          o_ready;
    logic                          o_valid;
    logic signed [DW-1:0]          o_out_w, o_out_x, o_out_y, o_out_z;

    // Shadow of the rotation registers, reset value q = (max, 0, 0, 0).
    logic signed [DW-1:0] rot [4] = '{MAXV[DW-1:0], '0, '0, '0};

    t_point point_q[$];     // points waiting to be offered
    t_quat  rotated_q[$];   // rotated points still owed by the DUT

    bit idle_on   = 1'b1;   // random bubbles on both channels
    int send_gap  = 0;      // sender bubble cycles left
    int recv_gap  = 0;      // receiver stall cycles left
    int hold_left = 0;      // long receiver hold-off, counted down by the monitor
    int mismatches = 0;

    quaternion_vector_rotate #(.DATA_WIDTH(DW)) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_point_x   (i_point_x),
        .i_point_y   (i_point_y),
        .i_point_z   (i_point_z),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_w     (o_out_w),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_out_z     (o_out_z)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Round to nearest (add half an LSB, floor) and clamp to the signed data range.
    function automatic logic signed [DW-1:0] round_sat(longint acc);
        longint r;
        r = (acc + (longint'(1) <<< (DW - 2))) >>> (DW - 1);
        if (r > MAXV)
            r = MAXV;
        else if (r < MINV)
            r = MINV;
        return r[DW-1:0];
    endfunction

    // Rotate one point by the shadow quaternion: t = p * conj(q), then r = q * t,
    // each component summed exactly and rounded/saturated after each product.
    function automatic t_quat rotate_point(t_point p);
        longint qw, qx, qy, qz, px, py, pz, tw, tx, ty, tz;
        t_quat  r;
        qw = rot[qvr_pkg::REG_ROT_W];
        qx = rot[qvr_pkg::REG_ROT_X];
        qy = rot[qvr_pkg::REG_ROT_Y];
        qz = rot[qvr_pkg::REG_ROT_Z];
        px = p.x;
        py = p.y;
        pz = p.z;
        tw = round_sat( px * qx + py * qy + pz * qz);
        tx = round_sat( px * qw - py * qz + pz * qy);
        ty = round_sat( px * qz + py * qw - pz * qx);
        tz = round_sat(-px * qy + py * qx + pz * qw);
        r.w = round_sat(qw * tw - qx * tx - qy * ty - qz * tz);
        r.x = round_sat(qw * tx + qx * tw + qy * tz - qz * ty);
        r.y = round_sat(qw * ty - qx * tz + qy * tw + qz * tx);
        r.z = round_sat(qw * tz + qx * ty - qy * tx + qz * tw);
        return r;
    endfunction

    // Driver: record each transfer, then offer the next point or a bubble.
    always @(posedge i_clk) begin
        t_point cur;
        t_point nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                cur.x = i_point_x;
                cur.y = i_point_y;
                cur.z = i_point_z;
                rotated_q.push_back(rotate_point(cur));
            end
            // Only advance when the bus is free; otherwise hold valid and payload.
            if (!i_valid || o_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (point_q.size() > 0) begin
                    nxt = point_q.pop_front();
                    i_valid   <= 1'b1;
                    i_point_x <= nxt.x;
                    i_point_y <= nxt.y;
                    i_point_z <= nxt.z;
                    if (idle_on && $urandom_range(0, 4) == 0)
                        send_gap = $urandom_range(1, 3);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(string name, logic signed [DW-1:0] want,
                                        logic signed [DW-1:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // Monitor: check each output transfer against the oldest owed result,
    // then decide whether to stall the next cycle.
    always @(posedge i_clk) begin
        t_quat want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (rotated_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, %s %0d %0d %0d %0d",
                             $time, "actual w x y z", o_out_w, o_out_x, o_out_y, o_out_z);
                end else begin
                    want = rotated_q.pop_front();
                    check_field("out_w", want.w, o_out_w);
                    check_field("out_x", want.x, o_out_x);
                    check_field("out_y", want.y, o_out_y);
                    check_field("out_z", want.z, o_out_z);
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                i_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                recv_gap = $urandom_range(0, 2);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Drive one register write; the shadow follows right away since the pipe is empty.
    task automatic write_rot(qvr_pkg::t_reg_idx idx, logic signed [DW-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        rot[idx] = val;
    endtask

    task automatic set_rotation(t_quat q);
        write_rot(qvr_pkg::REG_ROT_Z, q.z);
        write_rot(qvr_pkg::REG_ROT_X, q.x);
        write_rot(qvr_pkg::REG_ROT_W, q.w);
        write_rot(qvr_pkg::REG_ROT_Y, q.y);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Wait until every point is transferred and every result checked, then settle.
    task automatic drain();
        do
            @(negedge i_clk);
        while (point_q.size() != 0 || i_valid || rotated_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic t_quat make_quat(longint w, longint x, longint y, longint z);
        t_quat q;
        q.w = w[DW-1:0];
        q.x = x[DW-1:0];
        q.y = y[DW-1:0];
        q.z = z[DW-1:0];
        return q;
    endfunction

    function automatic t_point make_point(longint x, longint y, longint z);
        t_point p;
        p.x = x[DW-1:0];
        p.y = y[DW-1:0];
        p.z = z[DW-1:0];
        return p;
    endfunction

    // Roughly unit quaternion from random reals.
    function automatic t_quat random_unit_quat();
        real c [4];
        real norm;
        t_quat q;
        norm = 0.0;
        for (int k = 0; k < 4; k++) begin
            c[k] = $itor($urandom_range(0, 65535)) / 32767.5 - 1.0;
            norm += c[k] * c[k];
        end
        if (norm < 1.0e-3) begin
            c[0] = 1.0;
            norm = 1.0;
        end
        norm = $sqrt(norm);
        q.w = DW'(int'(c[0] / norm * 32767.0));
        q.x = DW'(int'(c[1] / norm * 32767.0));
        q.y = DW'(int'(c[2] / norm * 32767.0));
        q.z = DW'(int'(c[3] / norm * 32767.0));
        return q;
    endfunction

    function automatic logic signed [DW-1:0] edge_value();
        case ($urandom_range(0, 4))
            0:       return MAXV[DW-1:0];
            1:       return MINV[DW-1:0];
            2:       return '0;
            3:       return '1;
            default: return DW'(1);
        endcase
    endfunction

    // Mostly full-range points, some small ones, some built from edge values.
    function automatic t_point random_point();
        t_point  p;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            p.x = DW'($urandom);
            p.y = DW'($urandom);
            p.z = DW'($urandom);
        end else if (pick < 8) begin
            p.x = DW'($urandom_range(0, 4095) - 2048);
            p.y = DW'($urandom_range(0, 4095) - 2048);
            p.z = DW'($urandom_range(0, 4095) - 2048);
        end else begin
            p.x = edge_value();
            p.y = edge_value();
            p.z = edge_value();
        end
        return p;
    endfunction

    // Edge points: zero, all max, all min, mixed extremes, tiny values, a generic one.
    task automatic queue_edge_points();
        @(negedge i_clk);
        point_q.push_back(make_point(0, 0, 0));
        point_q.push_back(make_point(MAXV, MAXV, MAXV));
        point_q.push_back(make_point(MINV, MINV, MINV));
        point_q.push_back(make_point(MAXV, MINV, 0));
        point_q.push_back(make_point(-1, 1, -1));
        point_q.push_back(make_point(16384, -16384, 12345));
    endtask

    initial begin
        t_quat q;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset rotation (near identity).
        queue_edge_points();
        drain();
        // Non-unit q at both extremes: overflow clamps in t and in r.
        set_rotation(make_quat(MAXV, MAXV, MAXV, MAXV));
        queue_edge_points();
        drain();
        set_rotation(make_quat(MINV, MINV, MINV, MINV));
        queue_edge_points();
        drain();
        // Unit q, quarter turn about z.
        set_rotation(make_quat(23170, 0, 0, 23170));
        queue_edge_points();
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            if ($urandom_range(0, 2) == 0) begin
                q.w = DW'($urandom);
                q.x = DW'($urandom);
                q.y = DW'($urandom);
                q.z = DW'($urandom);
            end else begin
                q = random_unit_quat();
            end
            set_rotation(q);
            @(negedge i_clk);
            // Drop bubbles for the final stretch; stall the receiver hard once to fill the pipe.
            if (ph == 7)
                idle_on = 1'b0;
            if (ph == 2)
                hold_left = 300;
            repeat (150) point_q.push_back(random_point());
            drain();
        end

        if (mismatches == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb: done, errors");
        $finish;
    end

endmodule
